[rtl/core/esu8_pkg.sv]
// shared types and constants of the escaped string to utf-8 decoder
`timescale 1ns / 1ps

package esu8_pkg;

	// byte codes; the front uses all, the back only backslash and 'u'
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;

	// replacement character u+fffd
	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;

	localparam logic [7:0] TERM_RESET = 8'h22;

	// entries of the run queue between front and back
	localparam int QDEPTH = 4;

	// final part of a run: up to four bytes or the end marker
	typedef struct packed {
		logic [2:0]      len;
		logic            is_end;
		logic [3:0][7:0] bytes;
	} tail_t;

	// everything one input word causes on the output
	typedef struct packed {
		logic            pre_fffd;
		logic            flush;
		logic [1:0]      flush_cnt;
		logic [2:0][7:0] digits;
		tail_t           tail;
		logic [3:0]      total;
	} desc_t;

endpackage

[rtl/core/esu8_front.sv]
// front half: escape state machine, classifies each input word into a run
`timescale 1ns / 1ps

module esu8_front import esu8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       q_full,
	output logic       push,
	output desc_t      push_desc
);

	typedef enum logic [2:0] {
		PH_PLAIN,
		PH_ESC,
		PH_HEX,
		PH_WAIT_BS,
		PH_WAIT_U,
		PH_LOW
	} phase_t;

	function automatic tail_t f_none();
		tail_t t;
		t = '0;
		return t;
	endfunction

	function automatic tail_t f_byte(input logic [7:0] b);
		tail_t t;
		t = '0;
		t.len = 3'd1;
		t.bytes[0] = b;
		return t;
	endfunction

	function automatic tail_t f_end();
		tail_t t;
		t = '0;
		t.len = 3'd1;
		t.is_end = 1'b1;
		return t;
	endfunction

	function automatic tail_t f_utf8(input logic [20:0] cp);
		tail_t t;
		t = '0;
		if (cp <= 21'h00007F) begin
			t.len = 3'd1;
			t.bytes[0] = cp[7:0];
		end else if (cp <= 21'h0007FF) begin
			t.len = 3'd2;
			t.bytes[0] = {3'b110, cp[10:6]};
			t.bytes[1] = {2'b10, cp[5:0]};
		end else if (cp <= 21'h00FFFF) begin
			t.len = 3'd3;
			t.bytes[0] = {4'b1110, cp[15:12]};
			t.bytes[1] = {2'b10, cp[11:6]};
			t.bytes[2] = {2'b10, cp[5:0]};
		end else begin
			t.len = 3'd4;
			t.bytes[0] = {5'b11110, cp[20:18]};
			t.bytes[1] = {2'b10, cp[17:12]};
			t.bytes[2] = {2'b10, cp[11:6]};
			t.bytes[3] = {2'b10, cp[5:0]};
		end
		return t;
	endfunction

	// {valid, nibble}
	function automatic logic [4:0] f_hex(input logic [7:0] b);
		logic [4:0] r;
		r = '0;
		if (b inside {[8'h30:8'h39]}) begin
			r = {1'b1, b[3:0]};
		end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			r = {1'b1, b[3:0] + 4'd9};
		end
		return r;
	endfunction

	phase_t          phase_q, phase_d;
	logic [1:0]      cnt_q, cnt_d;
	logic [15:0]     acc_q, acc_d;
	logic [9:0]      pend_q, pend_d;
	logic [2:0][7:0] dig_q;
	logic [7:0]      term_q;

	logic        accept;
	logic        dig_we;
	logic [4:0]  hexr;
	logic [15:0] acc_next;
	logic [10:0] hi_plus;
	logic        grp_high;
	logic        grp_bad;
	tail_t       plain_tail, esc_tail, grp_tail, tail;
	phase_t      plain_phase, esc_phase, grp_phase;
	logic        pre, flush;
	logic [3:0]  flen;

	assign cfg_ready = 1'b1;
	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;

	assign hexr     = f_hex(in_byte);
	assign acc_next = {acc_q[11:0], hexr[3:0]};
	assign hi_plus  = {1'b0, pend_q} + 11'h040;
	assign grp_high = acc_next inside {[16'hD800:16'hDBFF]};
	assign grp_bad  = acc_next inside {[16'hDC00:16'hDFFF], [16'hFFFE:16'hFFFF]};

	// byte seen in plain text
	always_comb begin
		plain_phase = PH_PLAIN;
		if (in_byte == term_q) begin
			plain_tail = f_end();
		end else if (in_byte == CH_BSLASH) begin
			plain_tail  = f_none();
			plain_phase = PH_ESC;
		end else begin
			plain_tail = f_byte(in_byte);
		end
	end

	// byte after a backslash
	always_comb begin
		esc_phase = PH_PLAIN;
		case (in_byte)
			CH_R:    esc_tail = f_byte(CH_CR);
			CH_N:    esc_tail = f_byte(CH_LF);
			CH_T:    esc_tail = f_byte(CH_TAB);
			CH_U: begin
				esc_tail  = f_none();
				esc_phase = PH_HEX;
			end
			default: esc_tail = f_byte(in_byte);
		endcase
	end

	// a complete group of four digits
	always_comb begin
		if (grp_high) begin
			grp_tail  = f_none();
			grp_phase = PH_WAIT_BS;
		end else begin
			grp_tail  = f_utf8(grp_bad ? 21'h00FFFD : {5'b0, acc_next});
			grp_phase = PH_PLAIN;
		end
	end

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		acc_d   = acc_q;
		pend_d  = pend_q;
		dig_we  = 1'b0;
		pre     = 1'b0;
		flush   = 1'b0;
		tail    = f_none();
		case (phase_q)
			PH_ESC: begin
				tail    = esc_tail;
				phase_d = esc_phase;
				cnt_d   = 2'd0;
				acc_d   = 16'h0000;
			end
			PH_HEX: begin
				if (hexr[4]) begin
					dig_we = (cnt_q != 2'd3);
					acc_d  = acc_next;
					if (cnt_q == 2'd3) begin
						cnt_d   = 2'd0;
						tail    = grp_tail;
						phase_d = grp_phase;
						pend_d  = acc_next[9:0];
					end else begin
						cnt_d = cnt_q + 2'd1;
					end
				end else begin
					flush   = 1'b1;
					cnt_d   = 2'd0;
					tail    = plain_tail;
					phase_d = plain_phase;
				end
			end
			PH_WAIT_BS: begin
				if (in_byte == CH_BSLASH) begin
					phase_d = PH_WAIT_U;
				end else begin
					pre     = 1'b1;
					tail    = plain_tail;
					phase_d = plain_phase;
				end
			end
			PH_WAIT_U: begin
				if (in_byte == CH_U) begin
					phase_d = PH_LOW;
					cnt_d   = 2'd0;
					acc_d   = 16'h0000;
				end else begin
					pre     = 1'b1;
					tail    = esc_tail;
					phase_d = esc_phase;
					cnt_d   = 2'd0;
					acc_d   = 16'h0000;
				end
			end
			PH_LOW: begin
				if (hexr[4]) begin
					dig_we = (cnt_q != 2'd3);
					acc_d  = acc_next;
					if (cnt_q == 2'd3) begin
						cnt_d = 2'd0;
						if (acc_next inside {[16'hDC00:16'hDFFF]}) begin
							tail    = f_utf8({hi_plus, acc_next[9:0]});
							phase_d = PH_PLAIN;
						end else begin
							// high surrogate replaced, digits taken as a fresh escape
							pre     = 1'b1;
							tail    = grp_tail;
							phase_d = grp_phase;
							pend_d  = acc_next[9:0];
						end
					end else begin
						cnt_d = cnt_q + 2'd1;
					end
				end else begin
					pre     = 1'b1;
					flush   = 1'b1;
					cnt_d   = 2'd0;
					tail    = plain_tail;
					phase_d = plain_phase;
				end
			end
			default: begin
				tail    = plain_tail;
				phase_d = plain_phase;
			end
		endcase
	end

	assign flen = flush ? (4'd2 + {2'b00, cnt_q}) : 4'd0;

	always_comb begin
		push_desc           = '0;
		push_desc.pre_fffd  = pre;
		push_desc.flush     = flush;
		push_desc.flush_cnt = cnt_q;
		push_desc.digits    = dig_q;
		push_desc.tail      = tail;
		push_desc.total     = (pre ? 4'd3 : 4'd0) + flen + {1'b0, tail.len};
	end

	assign push = accept && (push_desc.total != 4'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLAIN;
			cnt_q   <= 2'd0;
			term_q  <= TERM_RESET;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				cnt_q   <= cnt_d;
			end
			if (cfg_valid) begin
				term_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_q  <= acc_d;
			pend_q <= pend_d;
			if (dig_we) begin
				dig_q[cnt_q] <= in_byte;
			end
		end
	end

endmodule

[rtl/core/esu8_queue.sv]
// run queue between front and back halves
`timescale 1ns / 1ps

module esu8_queue import esu8_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	output logic  full,
	output logic  valid,
	output desc_t head,
	input  logic  pop
);

	localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	desc_t         mem_q [QDEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full  = (cnt_q == CW'(QDEPTH));
	assign valid = (cnt_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(QDEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(QDEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule

[rtl/core/esu8_back.sv]
// back half: plays out one run a word per cycle while out_ready is high
`timescale 1ns / 1ps

module esu8_back import esu8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  desc_t      q_desc,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       last_of_run,
	output logic       string_end
);

	logic       busy_q;
	desc_t      desc_q;
	logic [3:0] idx_q;

	logic       last;
	logic [3:0] pre_len, flen, j, t, d;
	logic [7:0] sel;

	assign pre_len = desc_q.pre_fffd ? 4'd3 : 4'd0;
	assign flen    = desc_q.flush ? (4'd2 + {2'b00, desc_q.flush_cnt}) : 4'd0;
	assign j       = idx_q - pre_len;
	assign t       = j - flen;
	assign d       = j - 4'd2;
	assign last    = (idx_q == desc_q.total - 4'd1);

	always_comb begin
		if (idx_q < pre_len) begin
			case (idx_q[1:0])
				2'd0:    sel = REPL_B0;
				2'd1:    sel = REPL_B1;
				default: sel = REPL_B2;
			endcase
		end else if (j < flen) begin
			if (j == 4'd0) begin
				sel = CH_BSLASH;
			end else if (j == 4'd1) begin
				sel = CH_U;
			end else begin
				sel = desc_q.digits[d[1:0]];
			end
		end else begin
			sel = desc_q.tail.bytes[t[1:0]];
		end
	end

	assign out_valid   = busy_q;
	assign last_of_run = last;
	assign string_end  = desc_q.tail.is_end && last;
	assign byte_valid  = !string_end;
	assign out_byte    = string_end ? 8'h00 : sel;
	assign q_pop       = q_valid && (!busy_q || (out_ready && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 4'd0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q  <= 4'd0;
		end else if (busy_q && out_ready) begin
			if (last) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			desc_q <= q_desc;
		end
	end

endmodule

[rtl/core/escaped_string_to_utf8.sv]
// top level of the escaped string to utf-8 decoder
// an input word is written into the run queue, then loaded into the back player
// throughput: one input word per cycle while the queue has room; one output word
//   per cycle while out_ready is high; a word of n bytes gives n output words
// the four-entry run queue absorbs expansions while input keeps flowing
// reset: arst_n clears phase, queue and player; terminator returns to 0x22
`timescale 1ns / 1ps

module escaped_string_to_utf8 import esu8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// terminator register write
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	// raw string bytes in
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	// decoded bytes out
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       last_of_run,
	output logic       string_end
);

	// runs from the classifier waiting to be played out
	logic  push;
	desc_t push_desc;
	logic  q_full;
	logic  q_valid;
	desc_t q_head;
	logic  q_pop;

	// front: escape state machine, one word in per cycle while the queue has room
	esu8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.q_full    (q_full),
		.push      (push),
		.push_desc (push_desc)
	);

	// queue: words that give no output are never stored
	esu8_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (q_full),
		.valid     (q_valid),
		.head      (q_head),
		.pop       (q_pop)
	);

	// back: replacement prefix, literal flush, then tail bytes or end marker
	esu8_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_desc      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.last_of_run (last_of_run),
		.string_end  (string_end)
	);

endmodule

[test/utf8_decode_checker.sv]
// checker for the escaped string decoder: predicts every output word and compares
`timescale 1ns / 1ps

module utf8_decode_checker import esu8_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] out_byte,
	input  logic       byte_valid,
	input  logic       last_of_run,
	input  logic       string_end,
	output int         fail_count,
	output int         words_owed
);

	typedef enum logic [2:0] {
		M_TEXT, M_ESC, M_HEX, M_AWAIT_BS, M_AWAIT_U, M_LOW
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       run_end;
		logic       str_end;
	} out_word_t;

	out_word_t  decoded_q[$];
	out_word_t  run_q[$];
	scan_mode_t mode = M_TEXT;
	logic [2:0]  n_hex = '0;
	logic [15:0] acc = '0;
	logic [9:0]  hi_half = '0;
	logic [7:0]  dig [3];
	logic [7:0]  term = TERM_RESET;
	int          mism = 0;

	task automatic report(input string msg);
		mism++;
		$display("[%0t] decode check: %s", $time, msg);
	endtask

	function automatic void put(input logic [7:0] d, input logic hb, input logic se);
		out_word_t w;
		w = '{data: d, has_byte: hb, run_end: 1'b0, str_end: se};
		run_q = {run_q, w};
	endfunction

	function automatic void put_repl();
		put(REPL_B0, 1'b1, 1'b0);
		put(REPL_B1, 1'b1, 1'b0);
		put(REPL_B2, 1'b1, 1'b0);
	endfunction

	function automatic int hex_of(input logic [7:0] b);
		if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
		if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
		if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
		return -1;
	endfunction

	function automatic void put_utf8(input logic [20:0] cp);
		if (cp <= 21'h7F) begin
			put(cp[7:0], 1'b1, 1'b0);
		end else if (cp <= 21'h7FF) begin
			put({3'b110, cp[10:6]}, 1'b1, 1'b0);
			put({2'b10, cp[5:0]}, 1'b1, 1'b0);
		end else if (cp <= 21'hFFFF) begin
			put({4'b1110, cp[15:12]}, 1'b1, 1'b0);
			put({2'b10, cp[11:6]}, 1'b1, 1'b0);
			put({2'b10, cp[5:0]}, 1'b1, 1'b0);
		end else begin
			put({5'b11110, cp[20:18]}, 1'b1, 1'b0);
			put({2'b10, cp[17:12]}, 1'b1, 1'b0);
			put({2'b10, cp[11:6]}, 1'b1, 1'b0);
			put({2'b10, cp[5:0]}, 1'b1, 1'b0);
		end
	endfunction

	function automatic void as_text(input logic [7:0] b);
		mode = M_TEXT;
		if (b == term) begin
			put(8'h00, 1'b0, 1'b1);
		end else if (b == CH_BSLASH) begin
			mode = M_ESC;
		end else begin
			put(b, 1'b1, 1'b0);
		end
	endfunction

	function automatic void as_escape(input logic [7:0] b);
		mode = M_TEXT;
		if (b == CH_R) put(CH_CR, 1'b1, 1'b0);
		else if (b == CH_N) put(CH_LF, 1'b1, 1'b0);
		else if (b == CH_T) put(CH_TAB, 1'b1, 1'b0);
		else if (b == CH_U) begin
			mode = M_HEX;
			n_hex = '0;
			acc = '0;
		end else put(b, 1'b1, 1'b0);
	endfunction

	// '\', 'u' and the digits taken so far
	function automatic void spill_digits();
		put(CH_BSLASH, 1'b1, 1'b0);
		put(CH_U, 1'b1, 1'b0);
		for (int i = 0; i < n_hex && i < 3; i++) put(dig[i], 1'b1, 1'b0);
	endfunction

	function automatic void group_done(input logic [15:0] code);
		n_hex = '0;
		if (code >= 16'hD800 && code <= 16'hDBFF) begin
			hi_half = code[9:0];
			mode = M_AWAIT_BS;
			return;
		end
		mode = M_TEXT;
		if ((code >= 16'hDC00 && code <= 16'hDFFF) || code == 16'hFFFE || code == 16'hFFFF)
			put_repl();
		else
			put_utf8({5'b0, code});
	endfunction

	function automatic bit grab_digit(input logic [7:0] b);
		int v;
		v = hex_of(b);
		if (v < 0) return 1'b0;
		if (n_hex < 3'd3) dig[n_hex[1:0]] = b;
		acc = {acc[11:0], v[3:0]};
		n_hex = n_hex + 3'd1;
		return 1'b1;
	endfunction

	task automatic unescape_byte(input logic [7:0] b);
		out_word_t w;
		case (mode)
			M_ESC: as_escape(b);
			M_HEX: begin
				if (grab_digit(b)) begin
					if (n_hex >= 3'd4) group_done(acc);
				end else begin
					spill_digits();
					n_hex = '0;
					as_text(b);
				end
			end
			M_AWAIT_BS: begin
				if (b == CH_BSLASH) begin
					mode = M_AWAIT_U;
				end else begin
					put_repl();
					as_text(b);
				end
			end
			M_AWAIT_U: begin
				if (b == CH_U) begin
					mode = M_LOW;
					n_hex = '0;
					acc = '0;
				end else begin
					put_repl();
					as_escape(b);
				end
			end
			M_LOW: begin
				if (grab_digit(b)) begin
					if (n_hex >= 3'd4) begin
						if (acc >= 16'hDC00 && acc <= 16'hDFFF) begin
							n_hex = '0;
							mode = M_TEXT;
							put_utf8(21'h10000 + {1'b0, hi_half, acc[9:0]});
						end else begin
							// high half stands alone, digits start a fresh group
							put_repl();
							group_done(acc);
						end
					end
				end else begin
					put_repl();
					spill_digits();
					n_hex = '0;
					as_text(b);
				end
			end
			default: as_text(b);
		endcase
		foreach (run_q[i]) begin
			w = run_q[i];
			w.run_end = (i == run_q.size() - 1);
			decoded_q = {decoded_q, w};
		end
		run_q.delete();
	endtask

	task automatic check_word();
		out_word_t w;
		if (decoded_q.size() == 0) begin
			report($sformatf("word %h with nothing outstanding", out_byte));
			return;
		end
		w = decoded_q.pop_front();
		if (out_byte !== w.data)
			report($sformatf("out_byte %h, want %h", out_byte, w.data));
		if (byte_valid !== w.has_byte)
			report($sformatf("byte_valid %b, want %b", byte_valid, w.has_byte));
		if (last_of_run !== w.run_end)
			report($sformatf("last_of_run %b, want %b", last_of_run, w.run_end));
		if (string_end !== w.str_end)
			report($sformatf("string_end %b, want %b", string_end, w.str_end));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode = M_TEXT;
			n_hex = '0;
			acc = '0;
			hi_half = '0;
			term = TERM_RESET;
			decoded_q.delete();
			run_q.delete();
			words_owed <= 0;
		end else begin
			if (in_valid && in_ready) unescape_byte(in_byte);
			if (cfg_valid && cfg_ready) term = cfg_data;
			if (out_valid && out_ready) check_word();
			words_owed <= decoded_q.size();
			fail_count <= mism;
		end
	end

endmodule

[test/escaped_string_to_utf8_tb.sv]
// top of the escaped string decoder testbench: stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module escaped_string_to_utf8_tb import esu8_pkg::*;;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic [7:0] cfg_data = 8'h00;
	logic       in_valid = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       out_ready = 1'b0;
	logic       cfg_ready;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       last_of_run;
	logic       string_end;

	int fail_count;
	int words_owed;

	// idle chances in percent, changed by the stimulus between phases
	int in_gap_pct = 27;
	int out_gap_pct = 79;
	// one-shot request for the long receiver hold-off
	bit hold_pending = 1'b0;
	// terminator the block currently holds, so tokens can aim at it
	logic [7:0] term_now = TERM_RESET;
	// raw bytes waiting to be offered
	logic [7:0] raw_q[$];

	escaped_string_to_utf8 dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.last_of_run (last_of_run),
		.string_end  (string_end)
	);

	utf8_decode_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.last_of_run (last_of_run),
		.string_end  (string_end),
		.fail_count  (fail_count),
		.words_owed  (words_owed)
	);

	// 10 ns clock
	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off counted here so the
	// run queue fills and the block has to drop in_ready
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (hold_pending) begin
				hold_pending = 1'b0;
				stall_left = 80;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= out_gap_pct);
			end
		end
	end

	// offer one word; random gaps in front of it, then hold until taken
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(0, 99) < in_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_all();
		while (raw_q.size() > 0) send_byte(raw_q.pop_front());
	endtask

	// stop offering and wait for every outstanding word, then keep waiting in case the
	// last byte is still being worked on without output
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_owed != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// terminator write, only ever with the block idle
	task automatic write_term(input logic [7:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		term_now = v;
	endtask

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] c;
		if (v < 4'd10) c = 8'h30 + {4'h0, v};
		else if ($urandom_range(0, 1) != 0) c = 8'h41 + {4'h0, v} - 8'd10;
		else c = 8'h61 + {4'h0, v} - 8'd10;
		return c;
	endfunction

	// a byte that ends a \u group early; often the terminator or a backslash
	function automatic logic [7:0] non_hex_byte();
		logic [7:0] b;
		do begin
			case ($urandom_range(0, 3))
				0: b = term_now;
				1: b = CH_BSLASH;
				default: b = 8'($urandom_range(0, 255));
			endcase
		end while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
			(b >= 8'h61 && b <= 8'h66));
		return b;
	endfunction

	// append one raw byte to the send queue
	task automatic add_raw(input logic [7:0] b);
		raw_q = {raw_q, b};
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++) add_raw(s[i]);
	endtask

	task automatic push_u(input logic [15:0] code);
		add_raw(CH_BSLASH);
		add_raw(CH_U);
		add_raw(hex_digit(code[15:12]));
		add_raw(hex_digit(code[11:8]));
		add_raw(hex_digit(code[7:4]));
		add_raw(hex_digit(code[3:0]));
	endtask

	// one random token: mostly well-formed escapes with random content,
	// the rest loose bytes that may break a sequence anywhere, or \u groups cut short
	task automatic add_token();
		int kind;
		int k;
		logic [7:0] r;
		logic [15:0] hi;
		kind = $urandom_range(0, 99);
		hi = 16'($urandom_range(16'hD800, 16'hDBFF));
		if (kind < 28) begin
			r = 8'($urandom_range(0, 255));
			add_raw(r);
		end else if (kind < 35) begin
			add_raw(term_now);
		end else if (kind < 50) begin
			add_raw(CH_BSLASH);
			case ($urandom_range(0, 5))
				0: r = CH_R;
				1: r = CH_N;
				2: r = CH_T;
				3: r = term_now;
				4: r = CH_BSLASH;
				default: r = 8'($urandom_range(0, 255));
			endcase
			add_raw(r);
		end else if (kind < 60) begin
			// \u cut short after up to three digits
			add_raw(CH_BSLASH);
			add_raw(CH_U);
			k = $urandom_range(0, 3);
			repeat (k) add_raw(hex_digit(4'($urandom_range(0, 15))));
			add_raw(non_hex_byte());
		end else begin
			case ($urandom_range(0, 10))
				0: push_u(16'($urandom_range(0, 16'h7F)));
				1: push_u(16'($urandom_range(16'h80, 16'h7FF)));
				2: push_u(16'($urandom_range(16'h800, 16'hFFFF)));
				3: push_u(16'($urandom_range(16'hDC00, 16'hDFFF)));   // lone low half
				4: push_u(16'hFFFE + 16'($urandom_range(0, 1)));      // noncharacters
				5, 6: begin
					push_u(hi);
					push_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
				end
				7: begin
					// high half, then anything but a backslash
					push_u(hi);
					do r = 8'($urandom_range(0, 255)); while (r == CH_BSLASH);
					add_raw(r);
				end
				8: begin
					// high half, backslash, then not 'u'
					push_u(hi);
					add_raw(CH_BSLASH);
					do r = 8'($urandom_range(0, 255)); while (r == CH_U);
					add_raw(r);
				end
				9: begin
					// second group that is usually not a low half
					push_u(hi);
					push_u(16'($urandom_range(0, 16'hFFFF)));
				end
				default: begin
					// second group cut short
					push_u(hi);
					add_raw(CH_BSLASH);
					add_raw(CH_U);
					k = $urandom_range(0, 3);
					repeat (k) add_raw(hex_digit(4'($urandom_range(0, 15))));
					add_raw(non_hex_byte());
				end
			endcase
		end
	endtask

	task automatic stream(input int n_bytes);
		int sent;
		sent = 0;
		while (sent < n_bytes) begin
			add_token();
			sent += raw_q.size();
			send_all();
		end
	endtask

	task automatic run_phase(input logic [7:0] term, input int gap_in, input int gap_out,
		input int n_bytes);
		write_term(term);
		in_gap_pct = gap_in;
		out_gap_pct = gap_out;
		stream(n_bytes);
	endtask

	initial begin : stimulus
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: byte extremes, plain text, terminator, escaped terminator,
		// tab escape, high half not followed by a backslash, and a second
		// group cut short after one digit
		add_raw(8'h00);
		add_raw(8'hFF);
		push_str("a\"\\\"\\t\\uD83dx\\uDBFF\\u1g");
		send_all();

		// sender mostly offering, receiver mostly stalled; terminator at both extremes
		run_phase(8'h00, 27, 79, 55);
		run_phase(8'hFF, 27, 79, 55);
		// roles swapped; a backslash terminator only escapes after a high half
		run_phase(CH_BSLASH, 79, 27, 55);
		run_phase(8'h27, 79, 27, 55);
		// no idling at all
		run_phase(TERM_RESET, 0, 0, 55);

		// long receiver hold-off while the sender keeps streaming
		hold_pending = 1'b1;
		stream(40);

		drain();
		if (fail_count == 0 && words_owed == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/esu8_pkg.sv
rtl/core/esu8_front.sv
rtl/core/esu8_queue.sv
rtl/core/esu8_back.sv
rtl/core/escaped_string_to_utf8.sv
test/utf8_decode_checker.sv
test/escaped_string_to_utf8_tb.sv
